// ----- rtl/cfc_pkg.sv -----
// Shared types and constants for the control frame classifier.
// Used by cfc_regs, cfc_count, cfc_decide and control_frame_classifier.
package cfc_pkg;

  localparam int MAX_FRAME_BYTES = 4096;
  localparam int CNT_W           = $clog2(MAX_FRAME_BYTES + 1);
  localparam int BYTE_W          = 8;
  localparam int THR_W           = 9;
  localparam int MAXC_W          = 13;
  localparam int PROD_W          = CNT_W + THR_W;
  localparam int LEN_CMP_W       = (CNT_W > MAXC_W) ? CNT_W : MAXC_W;
  localparam int ADDR_W          = 4;
  localparam int DATA_W          = 32;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME_BYTES);

  typedef enum logic [1:0] {
    CLASS_NONE     = 2'd0,
    CLASS_PREAMBLE = 2'd1,
    CLASS_EOT      = 2'd2
  } frame_class_t;

  typedef enum logic [1:0] {
    REG_PREAMBLE_CODE     = 2'd0,
    REG_EOT_CODE          = 2'd1,
    REG_THRESHOLD_Q8      = 2'd2,
    REG_MAX_CONTROL_BYTES = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [BYTE_W-1:0] preamble_code;
    logic [BYTE_W-1:0] eot_code;
    logic [THR_W-1:0]  threshold_q8;
    logic [MAXC_W-1:0] max_control_bytes;
  } cfc_cfg_t;

  typedef struct packed {
    logic [CNT_W-1:0] length_count;
    logic [CNT_W-1:0] preamble_count;
    logic [CNT_W-1:0] eot_count;
  } cfc_counts_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v < CNT_MAX) ? CNT_W'(v + 1'b1) : CNT_MAX;
  endfunction

endpackage

// ----- rtl/control_frame_classifier.sv -----
// Control frame classifier top level: config registers, counting stage and
// classification stage. Depends on cfc_pkg, cfc_regs, cfc_count, cfc_decide.
// Throughput: one payload byte per cycle while out_ready keeps up, with no
// bubbles between frames. Counts go via the snapshot to the result register.
// The counting stage and the result register each hold one transaction.
// Reset (synchronous, rst high): counters cleared, outputs invalid, registers
// return to preamble 0, eot 255, threshold 128, control size 1024.
module control_frame_classifier import cfc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] payload_byte,
  input  logic              last_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        frame_class
);

  cfc_cfg_t    cfg;
  cfc_counts_t snap;
  logic        snap_valid;
  logic        snap_ready;

  cfc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cfc_count u_count (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .payload_byte (payload_byte),
    .last_byte    (last_byte),
    .snap_valid   (snap_valid),
    .snap_ready   (snap_ready),
    .snap         (snap)
  );

  cfc_decide u_decide (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .snap_valid  (snap_valid),
    .snap_ready  (snap_ready),
    .snap        (snap),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .frame_class (frame_class)
  );

endmodule

// ----- rtl/cfc_regs.sv -----
// APB-style configuration registers of the control frame classifier.
// Depends on cfc_pkg.
module cfc_regs import cfc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfc_cfg_t          cfg
);

  cfc_cfg_t   regs;
  reg_index_t index;
  logic       write_en;

  assign index    = reg_index_t'(paddr[3:2]);
  assign write_en = psel && penable && pwrite;
  assign pready   = 1'b1;
  assign cfg      = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.preamble_code     <= BYTE_W'(0);
      regs.eot_code          <= BYTE_W'(255);
      regs.threshold_q8      <= THR_W'(128);
      regs.max_control_bytes <= MAXC_W'(1024);
    end else if (write_en) begin
      unique case (index)
        REG_PREAMBLE_CODE:     regs.preamble_code     <= pwdata[BYTE_W-1:0];
        REG_EOT_CODE:          regs.eot_code          <= pwdata[BYTE_W-1:0];
        REG_THRESHOLD_Q8:      regs.threshold_q8      <= pwdata[THR_W-1:0];
        REG_MAX_CONTROL_BYTES: regs.max_control_bytes <= pwdata[MAXC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (index)
      REG_PREAMBLE_CODE:     prdata = DATA_W'(regs.preamble_code);
      REG_EOT_CODE:          prdata = DATA_W'(regs.eot_code);
      REG_THRESHOLD_Q8:      prdata = DATA_W'(regs.threshold_q8);
      REG_MAX_CONTROL_BYTES: prdata = DATA_W'(regs.max_control_bytes);
      default:               prdata = '0;
    endcase
  end

endmodule

// ----- rtl/cfc_count.sv -----
// Per-byte counting stage: saturating length and match counters, and a
// snapshot register that holds the final counts of a frame. Depends on cfc_pkg.
module cfc_count import cfc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cfc_cfg_t          cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] payload_byte,
  input  logic              last_byte,
  output logic              snap_valid,
  input  logic              snap_ready,
  output cfc_counts_t       snap
);

  cfc_counts_t counts;
  cfc_counts_t counts_next;
  logic        accept;

  assign in_ready = !snap_valid || snap_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    counts_next              = counts;
    counts_next.length_count = sat_inc(counts.length_count);
    if (payload_byte == cfg.preamble_code) begin
      counts_next.preamble_count = sat_inc(counts.preamble_count);
    end else if (payload_byte == cfg.eot_code) begin
      counts_next.eot_count = sat_inc(counts.eot_count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      counts     <= '0;
      snap_valid <= 1'b0;
    end else begin
      if (accept && last_byte) begin
        snap_valid <= 1'b1;
      end else if (snap_ready) begin
        snap_valid <= 1'b0;
      end
      if (accept) begin
        if (last_byte) begin
          counts <= '0;
        end else begin
          counts <= counts_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last_byte) begin
      snap <= counts_next;
    end
  end

endmodule

// ----- rtl/cfc_decide.sv -----
// Classification stage: length check, threshold ratio tests and the result
// register. Depends on cfc_pkg.
module cfc_decide import cfc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfc_cfg_t    cfg,
  input  logic        snap_valid,
  output logic        snap_ready,
  input  cfc_counts_t snap,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  frame_class
);

  logic [PROD_W-1:0] limit;
  logic [PROD_W-1:0] eot_scaled;
  logic [PROD_W-1:0] pre_scaled;
  logic              len_ok;
  frame_class_t      cls;

  assign snap_ready = !out_valid || out_ready;

  assign limit      = PROD_W'(cfg.threshold_q8) * PROD_W'(snap.length_count);
  assign eot_scaled = PROD_W'({snap.eot_count, 8'h00});
  assign pre_scaled = PROD_W'({snap.preamble_count, 8'h00});
  assign len_ok     = LEN_CMP_W'(snap.length_count) <= LEN_CMP_W'(cfg.max_control_bytes);

  always_comb begin
    priority if (!len_ok) begin
      cls = CLASS_NONE;
    end else if (eot_scaled > limit) begin
      cls = CLASS_EOT;
    end else if (pre_scaled > limit) begin
      cls = CLASS_PREAMBLE;
    end else begin
      cls = CLASS_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (snap_ready) begin
      out_valid <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_valid && snap_ready) begin
      frame_class <= cls;
    end
  end

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking bench for control_frame_classifier: directed table and
// randomized frames under randomized register settings.
// Depends on cfc_pkg and the control_frame_classifier RTL.
module tb_top;
  import cfc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  typedef struct packed {
    bit           is_write;
    reg_index_t   idx;
    logic [12:0]  value;
    logic [7:0]   data_byte;
    logic         last;
    bit           typed;
    frame_class_t cls;
  } script_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [BYTE_W-1:0] payload_byte = '0;
  logic              last_byte = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [1:0]        frame_class;

  control_frame_classifier DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  cfc_cfg_t         frame_cfg;
  logic [CNT_W-1:0] frame_len = '0;
  logic [CNT_W-1:0] preamble_hits = '0;
  logic [CNT_W-1:0] eot_hits = '0;
  frame_class_t     pending_classes[$];
  int unsigned      error_count = 0;
  int unsigned      tx_burst = 0;
  int unsigned      cycle_count = 0;

  script_row_t directed_steps [33] = '{
    '{1'b0, REG_PREAMBLE_CODE, 13'd0, 8'hFF, 1'b1, 1'b1, CLASS_EOT},
    '{1'b0, REG_PREAMBLE_CODE, 13'd0, 8'h00, 1'b1, 1'b1, CLASS_PREAMBLE},
    '{1'b0, REG_PREAMBLE_CODE, 13'd0, 8'h55, 1'b1, 1'b1, CLASS_NONE},
    '{1'b0, REG_PREAMBLE_CODE, 13'd0, 8'hFF, 1'b0, 1'b0, CLASS_NONE},
    '{1'b0, REG_PREAMBLE_CODE, 13'd0, 8'h00, 1'b1, 1'b1, CLASS_NONE},
    '{1'b0, REG_PREAMBLE_CODE, 13'd0, 8'hFF, 1'b0, 1'b0, CLASS_NONE},
    '{1'b0, REG_PREAMBLE_CODE, 13'd0, 8'hFF, 1'b0, 1'b0, CLASS_NONE},
    '{1'b0, REG_PREAMBLE_CODE, 13'd0, 8'h00, 1'b1, 1'b1, CLASS_EOT},
    '{1'b1, REG_PREAMBLE_CODE, 13'h5A, 8'h00, 1'b0, 1'b0, CLASS_NONE},
    '{1'b1, REG_EOT_CODE, 13'h5A, 8'h00, 1'b0, 1'b0, CLASS_NONE},
    '{1'b0, REG_PREAMBLE_CODE, 13'd0, 8'h5A, 1'b1, 1'b1, CLASS_PREAMBLE},
    '{1'b1, REG_THRESHOLD_Q8, 13'd256, 8'h00, 1'b0, 1'b0, CLASS_NONE},
    '{1'b0, REG_PREAMBLE_CODE, 13'd0, 8'h5A, 1'b1, 1'b1, CLASS_NONE},
    '{1'b1, REG_THRESHOLD_Q8, 13'd0, 8'h00, 1'b0, 1'b0, CLASS_NONE},
    '{1'b1, REG_MAX_CONTROL_BYTES, 13'd0, 8'h00, 1'b0, 1'b0, CLASS_NONE},
    '{1'b0, REG_PREAMBLE_CODE, 13'd0, 8'h5A, 1'b1, 1'b1, CLASS_NONE},
    '{1'b1, REG_MAX_CONTROL_BYTES, 13'd2, 8'h00, 1'b0, 1'b0, CLASS_NONE},
    '{1'b1, REG_EOT_CODE, 13'hA5, 8'h00, 1'b0, 1'b0, CLASS_NONE},
    '{1'b0, REG_PREAMBLE_CODE, 13'd0, 8'hA5, 1'b0, 1'b0, CLASS_NONE},
    '{1'b0, REG_PREAMBLE_CODE, 13'd0, 8'hA5, 1'b1, 1'b1, CLASS_EOT},
    '{1'b0, REG_PREAMBLE_CODE, 13'd0, 8'hA5, 1'b0, 1'b0, CLASS_NONE},
    '{1'b0, REG_PREAMBLE_CODE, 13'd0, 8'hA5, 1'b0, 1'b0, CLASS_NONE},
    '{1'b0, REG_PREAMBLE_CODE, 13'd0, 8'hA5, 1'b1, 1'b1, CLASS_NONE},
    '{1'b1, REG_THRESHOLD_Q8, 13'd511, 8'h00, 1'b0, 1'b0, CLASS_NONE},
    '{1'b1, REG_MAX_CONTROL_BYTES, 13'd8191, 8'h00, 1'b0, 1'b0, CLASS_NONE},
    '{1'b0, REG_PREAMBLE_CODE, 13'd0, 8'h5A, 1'b1, 1'b1, CLASS_NONE},
    '{1'b1, REG_THRESHOLD_Q8, 13'd0, 8'h00, 1'b0, 1'b0, CLASS_NONE},
    '{1'b0, REG_PREAMBLE_CODE, 13'd0, 8'h80, 1'b0, 1'b0, CLASS_NONE},
    '{1'b0, REG_PREAMBLE_CODE, 13'd0, 8'h7F, 1'b1, 1'b1, CLASS_NONE},
    '{1'b1, REG_THRESHOLD_Q8, 13'd1, 8'h00, 1'b0, 1'b0, CLASS_NONE},
    '{1'b0, REG_PREAMBLE_CODE, 13'd0, 8'hA5, 1'b0, 1'b0, CLASS_NONE},
    '{1'b0, REG_PREAMBLE_CODE, 13'd0, 8'h5A, 1'b0, 1'b0, CLASS_NONE},
    '{1'b0, REG_PREAMBLE_CODE, 13'd0, 8'h33, 1'b1, 1'b0, CLASS_NONE}
  };

  function automatic logic [CNT_W-1:0] bump_sat(input logic [CNT_W-1:0] v);
    return (v == CNT_W'(MAX_FRAME_BYTES)) ? v : v + 1'b1;
  endfunction

  function automatic bit beats_threshold(input logic [CNT_W-1:0] hits,
                                         input logic [CNT_W-1:0] len);
    return (32'(hits) << 8) > 32'(frame_cfg.threshold_q8) * 32'(len);
  endfunction

  task automatic classify_byte(input logic [7:0] b, input logic last, input bit typed,
                               input frame_class_t typed_cls);
    frame_class_t cls;
    cls = CLASS_NONE;
    frame_len = bump_sat(frame_len);
    if (b == frame_cfg.preamble_code) begin
      preamble_hits = bump_sat(preamble_hits);
    end else if (b == frame_cfg.eot_code) begin
      eot_hits = bump_sat(eot_hits);
    end
    if (last) begin
      if (32'(frame_len) <= 32'(frame_cfg.max_control_bytes)) begin
        if (beats_threshold(eot_hits, frame_len)) begin
          cls = CLASS_EOT;
        end else if (beats_threshold(preamble_hits, frame_len)) begin
          cls = CLASS_PREAMBLE;
        end
      end
      frame_len = '0;
      preamble_hits = '0;
      eot_hits = '0;
      pending_classes.push_back(typed ? typed_cls : cls);
    end
  endtask

  task automatic note_error(input string what, input logic [1:0] want, input logic [1:0] got);
    error_count++;
    if (error_count <= 10) begin
      $display("mismatch %0d at cycle %0d: %s expected %0d got %0d",
               error_count, cycle_count, what, want, got);
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last, input bit typed,
                           input frame_class_t typed_cls);
    int unsigned gap;
    if (tx_burst == 0) begin
      tx_burst = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    tx_burst--;
    in_valid <= 1'b1;
    payload_byte <= b;
    last_byte <= last;
    do @(posedge clk); while (!in_ready);
    classify_byte(b, last, typed, typed_cls);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_classes.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [12:0] value);
    logic [DATA_W-1:0] data;
    data = $urandom;
    case (idx)
      REG_PREAMBLE_CODE: begin
        data[BYTE_W-1:0] = value[BYTE_W-1:0];
        frame_cfg.preamble_code = value[BYTE_W-1:0];
      end
      REG_EOT_CODE: begin
        data[BYTE_W-1:0] = value[BYTE_W-1:0];
        frame_cfg.eot_code = value[BYTE_W-1:0];
      end
      REG_THRESHOLD_Q8: begin
        data[THR_W-1:0] = value[THR_W-1:0];
        frame_cfg.threshold_q8 = value[THR_W-1:0];
      end
      default: begin
        data[MAXC_W-1:0] = value[MAXC_W-1:0];
        frame_cfg.max_control_bytes = value[MAXC_W-1:0];
      end
    endcase
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 2'b00});
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  int unsigned    rx_left = 0;
  int unsigned    rx_mode = 0;
  logic [31:0]    rx_pattern = 32'h1;
  frame_class_t   rx_want;

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_classes.size() == 0) begin
        note_error("unexpected frame_class", 2'bxx, frame_class);
      end else begin
        rx_want = pending_classes.pop_front();
        if (frame_class !== rx_want) begin
          note_error("frame_class", rx_want, frame_class);
        end
      end
    end
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_left = $urandom_range(16, 96);
      rx_pattern = $urandom | 32'h1;
    end
    rx_left--;
    rx_pattern = {rx_pattern[30:0], rx_pattern[31]};
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= rx_pattern[0];
      default: out_ready <= rx_pattern[0] & rx_pattern[5];
    endcase
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned random_sent;
    int unsigned phase_end;
    int unsigned flen;
    int unsigned pct_pre;
    int unsigned pct_eot;
    int unsigned roll;
    logic [7:0]  b;
    logic [12:0] value;

    frame_cfg = '{preamble_code: 8'd0, eot_code: 8'd255, threshold_q8: 9'd128,
                  max_control_bytes: 13'd1024};
    random_sent = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_steps[i]) begin
      if (directed_steps[i].is_write) begin
        drain();
        write_reg(directed_steps[i].idx, directed_steps[i].value);
      end else begin
        send_byte(directed_steps[i].data_byte, directed_steps[i].last,
                  directed_steps[i].typed, directed_steps[i].cls);
      end
    end

    while (random_sent < 1600) begin
      drain();
      write_reg(REG_PREAMBLE_CODE, 13'($urandom_range(0, 255)));
      value = ($urandom_range(0, 4) == 0) ? 13'(frame_cfg.preamble_code)
                                          : 13'($urandom_range(0, 255));
      write_reg(REG_EOT_CODE, value);
      case ($urandom_range(0, 9))
        0: value = 13'd0;
        1: value = 13'd256;
        2: value = 13'd511;
        3: value = 13'd255;
        default: value = 13'($urandom_range(0, 256));
      endcase
      write_reg(REG_THRESHOLD_Q8, value);
      case ($urandom_range(0, 9))
        0: value = 13'd0;
        1: value = 13'd1;
        2: value = 13'd4096;
        3: value = 13'd8191;
        4: value = 13'($urandom_range(0, 8191));
        default: value = 13'($urandom_range(2, 24));
      endcase
      write_reg(REG_MAX_CONTROL_BYTES, value);

      phase_end = random_sent + $urandom_range(150, 250);
      while (random_sent < phase_end) begin
        roll = $urandom_range(0, 19);
        if (roll == 0) begin
          flen = $urandom_range(33, 80);
        end else if (roll <= 3) begin
          flen = $urandom_range(9, 32);
        end else if (roll == 4 && frame_cfg.max_control_bytes inside {[1:100]}) begin
          flen = frame_cfg.max_control_bytes + $urandom_range(0, 2);
          flen = (flen > 1) ? flen - 1 : 1;
        end else begin
          flen = $urandom_range(1, 8);
        end
        pct_pre = $urandom_range(0, 100);
        pct_eot = $urandom_range(0, 100 - pct_pre);
        for (int unsigned n = 0; n < flen; n++) begin
          roll = $urandom_range(0, 99);
          if (roll < pct_pre) begin
            b = frame_cfg.preamble_code;
          end else if (roll < pct_pre + pct_eot) begin
            b = frame_cfg.eot_code;
          end else begin
            b = 8'($urandom_range(0, 255));
          end
          send_byte(b, n == flen - 1, 1'b0, CLASS_NONE);
        end
        random_sent += flen;
      end
    end

    drain();
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
